>>> rtl/kewt_pkg.sv
// ----------------------------------------------------------------------------
// Keyed error window threshold: shared package
// Types, widths and codes used by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package kewt_pkg;

   // Default sizing of the entry table.
   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int KEY_BITS_DEF      = 64;

   // Fixed field widths.
   localparam int KEY_PORT_BITS = 64;
   localparam int TIME_BITS     = 64;
   localparam int COUNT_BITS    = 16;
   localparam int SLOT_BITS     = 4;
   localparam int WINDOW_BITS   = 20;
   localparam int NS_BITS       = 30;
   localparam int LIMIT_BITS    = WINDOW_BITS + NS_BITS;

   localparam logic [NS_BITS-1:0] NS_PER_SEC = NS_BITS'(1000000000);

   // Configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_SECONDS  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CORRECTED_THR   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNCORRECTED_THR = 2'd2;

   // One table record apart from its key.
   typedef struct packed {
      logic [COUNT_BITS-1:0] ce;
      logic [COUNT_BITS-1:0] uce;
      logic                  flagged;
      logic [TIME_BITS-1:0]  start;
   } rec_type;

   // Controller state, one-hot.
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SEARCH = 6'b000010,
      ST_RDREC  = 6'b000100,
      ST_DIFF   = 6'b001000,
      ST_UPDATE = 6'b010000,
      ST_EMPTY  = 6'b100000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic search_start;
      logic search_step;
      logic take_hit;
      logic alloc;
      logic diff;
      logic commit;
      logic load_zero;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic key_zero;
      logic hit;
      logic miss;
      logic full;
   } sts_type;

endpackage

>>> rtl/kewt_ctrl.sv
// ----------------------------------------------------------------------------
// Keyed error window threshold: controller
// Sequences capture, key search, record read, window check and update, and
// owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module kewt_ctrl
   import kewt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The result register can take a new item when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (sts.key_zero) begin
                  state_in = ST_EMPTY;
               end else begin
                  cmd.search_start = 1'b1;
                  state_in         = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            cmd.search_step = 1'b1;
            if (sts.hit) begin
               cmd.take_hit = 1'b1;
               state_in     = ST_RDREC;
            end else if (sts.miss) begin
               if (sts.full) begin
                  state_in = ST_EMPTY;
               end else begin
                  cmd.alloc = 1'b1;
                  state_in  = ST_DIFF;
               end
            end
         end
         ST_RDREC: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               cmd.load_zero = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag: set on load, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit || cmd.load_zero) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/kewt_dp.sv
// ----------------------------------------------------------------------------
// Keyed error window threshold: datapath
// Holds the configuration, the key and record memories, the search pipeline,
// the window arithmetic and the result register.
// ----------------------------------------------------------------------------
module kewt_dp
   import kewt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int KEY_BITS      = KEY_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   input  logic [KEY_PORT_BITS-1:0]  req_module_key,
   input  logic                      req_is_uncorrectable,
   input  logic [TIME_BITS-1:0]      req_time_ns,
   input  cmd_type                   cmd,
   output sts_type                   sts,
   output logic                      rsp_advise,
   output logic                      rsp_accepted,
   output logic [SLOT_BITS-1:0]      rsp_slot,
   output logic [COUNT_BITS-1:0]     rsp_corrected_count,
   output logic [COUNT_BITS-1:0]     rsp_uncorrected_count
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

   // Configuration registers and the window length in nanoseconds.
   logic [WINDOW_BITS-1:0] window_ff;
   logic [COUNT_BITS-1:0]  cthr_ff;
   logic [COUNT_BITS-1:0]  uthr_ff;
   logic [LIMIT_BITS-1:0]  limit_ff, limit_in;

   // Captured item.
   logic [KEY_BITS-1:0]  key_ff;
   logic                 uce_ff;
   logic [TIME_BITS-1:0] time_ff;

   // Table.
   logic [KEY_BITS-1:0] key_mem [TABLE_ENTRIES];
   rec_type             rec_mem [TABLE_ENTRIES];
   logic [CW-1:0]       used_ff;

   // Search pipeline.
   logic [CW-1:0]       idx_ff;
   logic [KEY_BITS-1:0] rd_key_ff;
   logic [CW-1:0]       rd_idx_ff;
   logic                rd_vld_ff;
   logic                rd_live_ff;

   // Selected entry and its record.
   logic [AW-1:0]        slot_ff;
   logic                 fresh_ff;
   rec_type              rec_rd_ff;
   rec_type              rec_view;
   rec_type              fresh_rec;
   logic [TIME_BITS-1:0] diff_ff;

   // Update logic.
   logic            expired;
   rec_type         rec_base;
   rec_type         rec_new;
   logic            adv;

   // Result register.
   logic                  out_adv_ff;
   logic                  out_acc_ff;
   logic [SLOT_BITS-1:0]  out_slot_ff;
   logic [COUNT_BITS-1:0] out_ce_ff;
   logic [COUNT_BITS-1:0] out_uce_ff;

   // Configuration writes; the limit is registered from the window setting in the cycle after.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         cthr_ff   <= '0;
         uthr_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WINDOW_SECONDS:  window_ff <= csr_data[WINDOW_BITS-1:0];
            CSR_CORRECTED_THR:   cthr_ff   <= csr_data[COUNT_BITS-1:0];
            CSR_UNCORRECTED_THR: uthr_ff   <= csr_data[COUNT_BITS-1:0];
            default:             ;
         endcase
      end
   end

   assign limit_in = LIMIT_BITS'(window_ff) * LIMIT_BITS'(NS_PER_SEC);

   always_ff @(posedge clock) begin
      limit_ff <= limit_in;
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff  <= req_module_key[KEY_BITS-1:0];
         uce_ff  <= req_is_uncorrectable;
         time_ff <= req_time_ns;
      end
   end

   // Fill count of the table.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.alloc) begin
         used_ff <= used_ff + CW'(1);
      end
   end

   // Key search: one entry read per cycle, compared in the next cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         rd_live_ff <= 1'b0;
      end else if (cmd.search_start) begin
         idx_ff     <= '0;
         rd_live_ff <= 1'b0;
      end else if (cmd.search_step) begin
         if (idx_ff != used_ff) begin
            idx_ff <= idx_ff + CW'(1);
         end
         rd_live_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[idx_ff[AW-1:0]];
      rd_idx_ff <= idx_ff;
      rd_vld_ff <= (idx_ff < used_ff);
   end

   assign sts.key_zero = (req_module_key[KEY_BITS-1:0] == '0);
   assign sts.hit      = rd_live_ff && rd_vld_ff && (rd_key_ff == key_ff);
   assign sts.miss     = rd_live_ff && !rd_vld_ff;
   assign sts.full     = (used_ff == FULL_COUNT);

   // Key memory write on allocation.
   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         key_mem[used_ff[AW-1:0]] <= key_ff;
      end
   end

   // Selected slot and whether it is a new entry.
   always_ff @(posedge clock) begin
      if (cmd.take_hit) begin
         slot_ff  <= rd_idx_ff[AW-1:0];
         fresh_ff <= 1'b0;
      end else if (cmd.alloc) begin
         slot_ff  <= used_ff[AW-1:0];
         fresh_ff <= 1'b1;
      end
   end

   // Record memory: registered read at the selected slot, write on commit.
   always_ff @(posedge clock) begin
      rec_rd_ff <= rec_mem[slot_ff];
      if (cmd.commit) begin
         rec_mem[slot_ff] <= rec_new;
      end
   end

   // A new entry starts with zero counts and its window at the item's time.
   always_comb begin
      fresh_rec         = '0;
      fresh_rec.start   = time_ff;
      rec_view          = fresh_ff ? fresh_rec : rec_rd_ff;
   end

   // Time since the window started, modulo 2^64.
   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         diff_ff <= time_ff - rec_view.start;
      end
   end

   // Window restart, saturating count and one-time advise.
   always_comb begin
      expired  = (window_ff != '0) && (diff_ff > TIME_BITS'(limit_ff));
      rec_base = rec_view;
      if (expired) begin
         rec_base.ce      = '0;
         rec_base.uce     = '0;
         rec_base.flagged = 1'b0;
         rec_base.start   = time_ff;
      end
      rec_new = rec_base;
      if (uce_ff) begin
         if (rec_base.uce != '1) begin
            rec_new.uce = rec_base.uce + COUNT_BITS'(1);
         end
      end else begin
         if (rec_base.ce != '1) begin
            rec_new.ce = rec_base.ce + COUNT_BITS'(1);
         end
      end
      adv = !rec_base.flagged && ((rec_new.uce >= uthr_ff) || (rec_new.ce >= cthr_ff));
      rec_new.flagged = rec_base.flagged || adv;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_adv_ff  <= adv;
         out_acc_ff  <= 1'b1;
         out_slot_ff <= SLOT_BITS'(slot_ff);
         out_ce_ff   <= rec_new.ce;
         out_uce_ff  <= rec_new.uce;
      end else if (cmd.load_zero) begin
         out_adv_ff  <= 1'b0;
         out_acc_ff  <= 1'b0;
         out_slot_ff <= '0;
         out_ce_ff   <= '0;
         out_uce_ff  <= '0;
      end
   end

   assign rsp_advise            = out_adv_ff;
   assign rsp_accepted          = out_acc_ff;
   assign rsp_slot              = out_slot_ff;
   assign rsp_corrected_count   = out_ce_ff;
   assign rsp_uncorrected_count = out_uce_ff;

endmodule

>>> rtl/keyed_error_window_threshold_top.sv
// ----------------------------------------------------------------------------
// Keyed error window threshold: top level
// Per-module memory error counting with a time window and one-time advise.
// ----------------------------------------------------------------------------
// Each item is one memory error event and yields exactly one result. An item
// with an empty key, or a new key while the table is full, gives an all-zero
// result. The key search reads the key memory one entry per cycle, so an item
// takes longer the later its key is found in the table or, for a new key, the
// more entries are in use. The next item is accepted once the previous one has
// reached the result register, even while that result still waits to be
// taken. The table needs no clearing after reset.
module keyed_error_window_threshold_top
   import kewt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
   parameter int KEY_BITS      = KEY_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [KEY_PORT_BITS-1:0]  req_module_key,
   input  logic                      req_is_uncorrectable,
   input  logic [TIME_BITS-1:0]      req_time_ns,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_advise,
   output logic                      rsp_accepted,
   output logic [SLOT_BITS-1:0]      rsp_slot,
   output logic [COUNT_BITS-1:0]     rsp_corrected_count,
   output logic [COUNT_BITS-1:0]     rsp_uncorrected_count
);

   cmd_type cmd;
   sts_type sts;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   // Controller.
   kewt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath.
   kewt_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .KEY_BITS      (KEY_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .req_module_key        (req_module_key),
      .req_is_uncorrectable  (req_is_uncorrectable),
      .req_time_ns           (req_time_ns),
      .cmd                   (cmd),
      .sts                   (sts),
      .rsp_advise            (rsp_advise),
      .rsp_accepted          (rsp_accepted),
      .rsp_slot              (rsp_slot),
      .rsp_corrected_count   (rsp_corrected_count),
      .rsp_uncorrected_count (rsp_uncorrected_count)
   );

`ifndef ASSERT_OFF
   // A result is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit || cmd.load_zero) |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten");

   // An item with an empty key never starts a table search.
   a_empty_no_search: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_module_key[KEY_BITS-1:0] == '0))
      |=> !cmd.search_step)
      else $error("empty key started a search");

   // A dropped or ignored item carries an all-zero result.
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> (!rsp_advise && (rsp_slot == '0)
         && (rsp_corrected_count == '0) && (rsp_uncorrected_count == '0)))
      else $error("dropped item has nonzero result fields");

   // An accepted item has counted at least one error.
   a_count_moved: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted)
      |-> ((rsp_corrected_count != '0) || (rsp_uncorrected_count != '0)))
      else $error("accepted item with both counts zero");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// Keyed error window threshold: testbench
// Sends memory error events and register writes through the handshake ports
// with random gaps on both sides. Each result is checked field by field
// against a cycle-free model of the entry table, its windows and its counts.
// ----------------------------------------------------------------------------
module tb_top;
   import kewt_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 5;
   localparam int ENTRIES         = TABLE_ENTRIES_DEF;
   localparam int STALL_LIMIT     = 3000;
   localparam int DRAIN_CYCLES    = 30;
   localparam logic [63:0] NANOS_PER_SEC = 64'd1_000_000_000;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 2'd3;

   // One result item as the block reports it.
   typedef struct packed {
      logic                  advise;
      logic                  accepted;
      logic [SLOT_BITS-1:0]  slot;
      logic [COUNT_BITS-1:0] ce;
      logic [COUNT_BITS-1:0] uce;
   } outcome_type;

   // Model of the entry table, the registers and the results still owed.
   class error_window_scoreboard;
      logic [KEY_PORT_BITS-1:0] key_of       [ENTRIES];
      logic [COUNT_BITS-1:0]    corr_tally   [ENTRIES];
      logic [COUNT_BITS-1:0]    uncorr_tally [ENTRIES];
      logic                     flagged      [ENTRIES];
      logic [TIME_BITS-1:0]     window_start [ENTRIES];
      logic [WINDOW_BITS-1:0]   window_sec;
      logic [COUNT_BITS-1:0]    ce_limit;
      logic [COUNT_BITS-1:0]    uce_limit;
      int                       used;
      int                       mismatches;
      int                       results_seen;
      int                       advised;
      int                       refused;
      outcome_type              pending_outcomes[$];

      function new();
         used         = 0;
         mismatches   = 0;
         results_seen = 0;
         advised      = 0;
         refused      = 0;
         window_sec   = '0;
         ce_limit     = '0;
         uce_limit    = '0;
      endfunction

      function int outstanding();
         return pending_outcomes.size();
      endfunction

      // Register writes; unused indexes are ignored and upper data bits dropped.
      function void set_register(logic [CSR_INDEX_BITS-1:0] reg_index,
                                 logic [CSR_DATA_BITS-1:0] data);
         case (reg_index)
            CSR_WINDOW_SECONDS: begin
               window_sec = data[WINDOW_BITS-1:0];
            end
            CSR_CORRECTED_THR: begin
               ce_limit = data[COUNT_BITS-1:0];
            end
            CSR_UNCORRECTED_THR: begin
               uce_limit = data[COUNT_BITS-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // Work out the result of one accepted event and update the table.
      function void note_event(logic [KEY_PORT_BITS-1:0] key, logic uncorrectable,
                               logic [TIME_BITS-1:0] now);
         outcome_type want;
         int          hit;
         int          idx;
         logic [63:0] elapsed;

         want = '0;
         hit  = -1;
         // The full key width is in use, so no masking of the key is needed.
         if (key != '0) begin
            for (idx = 0; idx < used; idx++) begin
               if (hit < 0 && key_of[idx] == key) begin
                  hit = idx;
               end
            end
            if (hit < 0 && used < ENTRIES) begin
               hit               = used;
               key_of[hit]       = key;
               corr_tally[hit]   = '0;
               uncorr_tally[hit] = '0;
               flagged[hit]      = 1'b0;
               window_start[hit] = now;
               used++;
            end
         end
         if (hit >= 0) begin
            // A window expires once strictly more than its length has passed.
            elapsed = now - window_start[hit];
            if (window_sec != '0 && elapsed > 64'(window_sec) * NANOS_PER_SEC) begin
               corr_tally[hit]   = '0;
               uncorr_tally[hit] = '0;
               flagged[hit]      = 1'b0;
               window_start[hit] = now;
            end
            if (uncorrectable) begin
               if (uncorr_tally[hit] != '1) uncorr_tally[hit]++;
            end else begin
               if (corr_tally[hit] != '1) corr_tally[hit]++;
            end
            if (!flagged[hit] &&
                (uncorr_tally[hit] >= uce_limit || corr_tally[hit] >= ce_limit)) begin
               flagged[hit] = 1'b1;
               want.advise  = 1'b1;
            end
            want.accepted = 1'b1;
            want.slot     = SLOT_BITS'(hit);
            want.ce       = corr_tally[hit];
            want.uce      = uncorr_tally[hit];
         end
         pending_outcomes.push_back(want);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      // Compare one result item with the oldest one still owed.
      function void check_result(outcome_type got);
         outcome_type want;

         results_seen++;
         if (pending_outcomes.size() == 0) begin
            $error("result item arrived with no event pending");
            mismatches++;
            return;
         end
         want = pending_outcomes.pop_front();
         compare_field("advise", 64'(want.advise), 64'(got.advise));
         compare_field("accepted", 64'(want.accepted), 64'(got.accepted));
         compare_field("slot", 64'(want.slot), 64'(got.slot));
         compare_field("corrected_count", 64'(want.ce), 64'(got.ce));
         compare_field("uncorrected_count", 64'(want.uce), 64'(got.uce));
         if (want.advise) advised++;
         if (!want.accepted) refused++;
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;
   logic                      req_valid;
   logic                      req_ready;
   logic [KEY_PORT_BITS-1:0]  req_module_key;
   logic                      req_is_uncorrectable;
   logic [TIME_BITS-1:0]      req_time_ns;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_advise;
   logic                      rsp_accepted;
   logic [SLOT_BITS-1:0]      rsp_slot;
   logic [COUNT_BITS-1:0]     rsp_corrected_count;
   logic [COUNT_BITS-1:0]     rsp_uncorrected_count;

   error_window_scoreboard   sb;
   logic [KEY_PORT_BITS-1:0] pool [ENTRIES];
   logic [TIME_BITS-1:0]     now_ns;
   int                       send_idle_pct;
   int                       recv_idle_pct;
   int                       idle_cycles;

   keyed_error_window_threshold_top u_top (
      .clock                 (clock),
      .reset                 (reset),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_module_key        (req_module_key),
      .req_is_uncorrectable  (req_is_uncorrectable),
      .req_time_ns           (req_time_ns),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_advise            (rsp_advise),
      .rsp_accepted          (rsp_accepted),
      .rsp_slot              (rsp_slot),
      .rsp_corrected_count   (rsp_corrected_count),
      .rsp_uncorrected_count (rsp_uncorrected_count)
   );

   always #HALF_PERIOD clock = ~clock;

   // The receiver stalls at random, one decision per cycle.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Observe every handshake at the rising edge and watch for a hang.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            sb.check_result({rsp_advise, rsp_accepted, rsp_slot,
                             rsp_corrected_count, rsp_uncorrected_count});
         end
         if (req_valid && req_ready) begin
            sb.note_event(req_module_key, req_is_uncorrectable, req_time_ns);
         end
         if (csr_valid && csr_ready) begin
            sb.set_register(csr_index, csr_data);
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // A random nonzero key that is not one of the pool keys.
   function automatic logic [KEY_PORT_BITS-1:0] fresh_key();
      logic [KEY_PORT_BITS-1:0] k;
      bit                       clash;

      do begin
         k     = {$urandom(), $urandom()};
         clash = (k == '0);
         foreach (pool[i]) begin
            if (pool[i] == k) clash = 1'b1;
         end
      end while (clash);
      return k;
   endfunction

   // Offer one event, after a random gap, and hold it until it is taken.
   task automatic send_event(logic [KEY_PORT_BITS-1:0] key, logic uncorrectable,
                             logic [TIME_BITS-1:0] stamp);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid            <= 1'b1;
      req_module_key       <= key;
      req_is_uncorrectable <= uncorrectable;
      req_time_ns          <= stamp;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] reg_index,
                                 logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop offering events and wait until every result has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic apply_settings(logic [CSR_DATA_BITS-1:0] window,
                                 logic [CSR_DATA_BITS-1:0] ce_thr,
                                 logic [CSR_DATA_BITS-1:0] uce_thr);
      drain();
      write_register(CSR_WINDOW_SECONDS, window);
      write_register(CSR_CORRECTED_THR, ce_thr);
      write_register(CSR_UNCORRECTED_THR, uce_thr);
   endtask

   // Mostly known keys with time moving forward at several scales; some empty
   // keys, some unknown keys once the table is full, some jumps in time.
   task automatic send_random_event();
      logic [KEY_PORT_BITS-1:0] key;
      int                       pick;

      pick = $urandom_range(99);
      if (pick < 5) begin
         key = '0;
      end else if (pick < 13 && sb.used == ENTRIES) begin
         key = fresh_key();
      end else begin
         key = pool[$urandom_range(ENTRIES - 1)];
      end
      pick = $urandom_range(99);
      if (pick < 50) begin
         now_ns += 64'($urandom_range(1000));
      end else if (pick < 80) begin
         now_ns += 64'($urandom_range(2 * sb.window_sec + 2)) * NANOS_PER_SEC +
                   64'($urandom_range(1000));
      end else if (pick < 95) begin
         now_ns += {32'h0, $urandom()};
      end else begin
         now_ns = {$urandom(), $urandom()};
      end
      send_event(key, 1'($urandom_range(1)), now_ns);
   endtask

   task automatic run_phase(logic [CSR_DATA_BITS-1:0] window,
                            logic [CSR_DATA_BITS-1:0] ce_thr,
                            logic [CSR_DATA_BITS-1:0] uce_thr, int count);
      apply_settings(window, ce_thr, uce_thr);
      repeat (count) send_random_event();
   endtask

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      csr_valid            = 1'b0;
      csr_index            = '0;
      csr_data             = '0;
      req_valid            = 1'b0;
      req_module_key       = '0;
      req_is_uncorrectable = 1'b0;
      req_time_ns          = '0;
      rsp_ready            = 1'b0;
      idle_cycles          = 0;
      now_ns               = '0;
      send_idle_pct        = 14;
      recv_idle_pct        = 67;
      sb                   = new();

      // Key pool: all ones, lowest bit only, top bit only, then random keys.
      foreach (pool[i]) pool[i] = '0;
      pool[0] = '1;
      pool[1] = 64'h1;
      pool[2] = 64'h8000_0000_0000_0000;
      for (int i = 3; i < ENTRIES; i++) pool[i] = fresh_key();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zero thresholds: the first event of each entry advises at once.
      apply_settings(0, 0, 0);
      write_register(CSR_SPARE_INDEX, $urandom());
      send_event('0, 1'b0, '0);
      send_event('0, 1'b1, '1);
      send_event(pool[0], 1'b0, '0);
      send_event(pool[0], 1'b1, 64'd5);
      send_event(pool[1], 1'b1, '1);
      send_event(pool[2], 1'b0, NANOS_PER_SEC);

      // One-second window: exactly one window later is still inside it,
      // one nanosecond more restarts it.
      apply_settings(1, 2, 1);
      send_event(pool[0], 1'b0, NANOS_PER_SEC);
      send_event(pool[0], 1'b0, NANOS_PER_SEC + 1);
      send_event(pool[0], 1'b0, NANOS_PER_SEC + 2);
      // Time wrapped past the window start of this entry.
      send_event(pool[1], 1'b0, '0);
      send_event(pool[2], 1'b1, 3 * NANOS_PER_SEC);

      // Fill the table, then a new key is dropped.
      for (int i = 3; i < ENTRIES; i++) begin
         send_event(pool[i], 1'(i), 3 * NANOS_PER_SEC + 64'(i));
      end
      send_event(fresh_key(), 1'b0, 4 * NANOS_PER_SEC);
      now_ns = 4 * NANOS_PER_SEC;

      // Random phases under several register settings and idle patterns.
      run_phase(1, 3, 2, 300);
      run_phase(32'hFFFFF, 0, 32'hFFFF, 280);
      send_idle_pct = 67;
      recv_idle_pct = 14;
      run_phase(0, 5, 1, 300);
      run_phase(2, 32'hFFFF, 0, 280);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase(3, 4, 4, 300);
      run_phase({12'($urandom()), 20'($urandom_range(1, 8))},
                {16'($urandom()), 16'($urandom_range(1, 6))},
                {16'($urandom()), 16'($urandom_range(1, 6))}, 290);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d results: %0d advised, %0d refused for empty key or full table.",
               sb.results_seen, sb.advised, sb.refused);
      $display("Covered windows from none to the maximum, window restarts and time wrap.");
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
